[sv/sdd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and constant functions for the shortest double-to-decimal block.
// No dependencies; every other file imports this package.
package sdd_pkg;

  localparam int IN_W      = 63;
  localparam int SIG_W     = 57;
  localparam int EXP_W     = 10;
  localparam int MANT_BITS = 52;
  localparam int EXP_BIAS  = 1023;
  localparam int MUL_BITS  = 125;
  localparam int MUL_W     = MUL_BITS + 1;
  localparam int INV_ROWS  = 292;
  localparam int POW_ROWS  = 326;
  localparam int ROW_AW    = 9;
  localparam int ACC_W     = 192;
  localparam int E2_OFFSET = EXP_BIAS + MANT_BITS + 2;

  localparam logic [47:0] LOG10_2_MUL   = 48'd169464822037455;
  localparam logic [47:0] LOG10_5_MUL   = 48'd196742565691928;
  localparam logic [20:0] POW5_BITS_MUL = 21'd1217359;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_LOG, S_SH, S_MUL, S_MULW, S_WIN, S_TZ,
    S_P5F, S_P5FW, S_P5L, S_P5W, S_RISS, S_RWAIT, S_RDEC, S_FIN
  } sdd_state_t;

  typedef enum logic [1:0] {P5_VR, P5_VM, P5_VP} p5_mode_t;

  typedef struct packed {
    logic       clr;
    logic       valid;
    logic [2:0] pos;
  } mac_ctl_t;

  typedef logic [INV_ROWS-1:0][MUL_W-1:0] inv_tbl_t;
  typedef logic [POW_ROWS-1:0][MUL_W-1:0] pow_tbl_t;

  // Bit length of 5^n.
  function automatic logic [9:0] pow5_bits(input logic [ROW_AW-1:0] n);
    logic [29:0] p;
    p = 30'(n) * 30'(POW5_BITS_MUL);
    return 10'(p >> 19) + 10'd1;
  endfunction

  // Top MUL_BITS bits of 5^n.
  function automatic pow_tbl_t build_pow_tbl();
    pow_tbl_t      tbl;
    logic [1023:0] p;
    logic [1023:0] w;
    int            b;
    tbl = '0;
    p   = 1024'd1;
    for (int n = 0; n < POW_ROWS; n++) begin
      b      = int'(pow5_bits(ROW_AW'(n)));
      w      = (p << MUL_BITS) >> b;
      tbl[n] = MUL_W'(w);
      p      = p * 1024'd5;
    end
    return tbl;
  endfunction

  // floor(2^(b-1+MUL_BITS) / 5^n) + 1, worked out by restoring long division
  // over the single set bit of the dividend.
  function automatic inv_tbl_t build_inv_tbl();
    inv_tbl_t      tbl;
    logic [1023:0] p;
    logic [1023:0] r;
    logic [MUL_W-1:0] quo;
    int            b;
    int            top;
    tbl = '0;
    p   = 1024'd1;
    for (int n = 0; n < INV_ROWS; n++) begin
      b   = int'(pow5_bits(ROW_AW'(n)));
      top = b - 1 + MUL_BITS;
      r   = '0;
      quo = '0;
      for (int k = top; k >= 0; k--) begin
        r   = {r[1022:0], (k == top) ? 1'b1 : 1'b0};
        quo = {quo[MUL_W-2:0], 1'b0};
        if (r >= p) begin
          r      = r - p;
          quo[0] = 1'b1;
        end
      end
      tbl[n] = quo + MUL_W'(1);
      p      = p * 1024'd5;
    end
    return tbl;
  endfunction

endpackage

[sv/sdd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input doubles and decimal results.
// Depends on sdd_pkg for field widths.
interface sdd_in_if import sdd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] double_bits;
  modport source (output valid, output double_bits, input ready);
  modport sink   (input valid, input double_bits, output ready);
endinterface

interface sdd_out_if import sdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SIG_W-1:0]        decimal_significand;
  logic signed [EXP_W-1:0] decimal_exponent;
  modport source (output valid, output decimal_significand, output decimal_exponent,
                  input ready);
  modport sink   (input valid, input decimal_significand, input decimal_exponent,
                  output ready);
endinterface

[sv/shortest_double_to_decimal.sv]
`timescale 1ns / 1ps
// Top level: shortest round-trip decimal of a positive binary64 value.
// Depends on sdd_pkg, sdd_if, sdd_rom, sdd_mac and sdd_div10.
//
//   Channel  Dir  Beat fields                              Handshake
//   in_ch    in   double_bits[62:0]                        valid/ready
//   out_ch   out  decimal_significand[56:0],               valid/ready
//                 decimal_exponent[9:0] (signed)
//
// Each beat runs one digit round per decimal digit dropped and one more round,
// plus the power-of-five divisibility check when it runs (q up to 21). The
// divide-by-ten pipeline is shared by the divisibility check and every digit round.
// A zero input goes straight from decode to the finish step with a zero result.
// Reset is synchronous and active low; it clears the sequencer and the result valid.
// A waiting result sits in the output register, so the next beat may be accepted
// while the result side stalls; the finish step waits only if that register is full.
module shortest_double_to_decimal import sdd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sdd_in_if.sink    in_ch,
  sdd_out_if.source out_ch
);

  sdd_state_t state_r, state_nxt;

  // Decoded operand.
  logic [IN_W-1:0]   bits_r, bits_nxt;
  logic              zero_r, zero_nxt;
  logic [54:0]       mv_r, mv_nxt;
  logic signed [11:0] e2_r, e2_nxt;
  logic              accept_r, accept_nxt;
  logic              mm_r, mm_nxt;
  logic              ge_r, ge_nxt;
  logic [9:0]        q_r, q_nxt;
  logic [9:0]        e10_r, e10_nxt;
  logic [ROW_AW-1:0] idx_r, idx_nxt;
  logic [7:0]        amt_r, amt_nxt;

  // Sequencing counters.
  logic [2:0]        k_r, k_nxt;
  logic [1:0]        wcnt_r, wcnt_nxt;
  logic [1:0]        iss_r, iss_nxt;
  logic [1:0]        cap_r, cap_nxt;
  logic [4:0]        cnt_r, cnt_nxt;

  // Interval values and digit-removal state.
  logic [ACC_W-1:0]  tmp_r, tmp_nxt;
  logic [63:0]       vr_r, vr_nxt, vp_r, vp_nxt, vm_r, vm_nxt;
  logic [63:0]       qvr_r, qvr_nxt, qvp_r, qvp_nxt, qvm_r, qvm_nxt;
  logic [3:0]        rvr_r, rvr_nxt, rvm_r, rvm_nxt;
  logic [54:0]       t_r, t_nxt;
  p5_mode_t          mode_r, mode_nxt;
  logic              vr_tz_r, vr_tz_nxt, vm_tz_r, vm_tz_nxt;
  logic [3:0]        last_r, last_nxt;
  logic [4:0]        removed_r, removed_nxt;
  logic              trail_r, trail_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [SIG_W-1:0]  sig_r, sig_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;

  // Shared units.
  logic [MUL_W-1:0]  rom_q;
  logic [127:0]      m_ext;
  mac_ctl_t          mac_ctl;
  logic [31:0]       mac_a, mac_b;
  logic [ACC_W-1:0]  acc;
  logic              dv_in_valid, dv_out_valid;
  logic [63:0]       dv_in, dv_quo;
  logic [3:0]        dv_rem;

  // Scratch terms.
  logic [10:0]       xabs;
  logic [58:0]       lprod;
  logic [9:0]        lg, qv;
  logic [10:0]       ii;
  logic [9:0]        b5;
  logic signed [11:0] sh;
  logic [ACC_W-1:0]  shin, shv;
  logic [3:0]        lastf;
  logic              inc;
  logic [10:0]       ex;

  sdd_rom u_rom (
    .clk    (clk),
    .sel_inv(ge_r),
    .addr   (idx_r),
    .data_r (rom_q)
  );

  sdd_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .acc_r(acc)
  );

  sdd_div10 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_in_valid),
    .in_data  (dv_in),
    .out_valid(dv_out_valid),
    .out_quo  (dv_quo),
    .out_rem  (dv_rem)
  );

  assign m_ext                      = 128'(rom_q);
  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = out_valid_r;
  assign out_ch.decimal_significand = sig_r;
  assign out_ch.decimal_exponent    = exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r    <= bits_nxt;
    zero_r    <= zero_nxt;
    mv_r      <= mv_nxt;
    e2_r      <= e2_nxt;
    accept_r  <= accept_nxt;
    mm_r      <= mm_nxt;
    ge_r      <= ge_nxt;
    q_r       <= q_nxt;
    e10_r     <= e10_nxt;
    idx_r     <= idx_nxt;
    amt_r     <= amt_nxt;
    k_r       <= k_nxt;
    wcnt_r    <= wcnt_nxt;
    iss_r     <= iss_nxt;
    cap_r     <= cap_nxt;
    cnt_r     <= cnt_nxt;
    tmp_r     <= tmp_nxt;
    vr_r      <= vr_nxt;
    vp_r      <= vp_nxt;
    vm_r      <= vm_nxt;
    qvr_r     <= qvr_nxt;
    qvp_r     <= qvp_nxt;
    qvm_r     <= qvm_nxt;
    rvr_r     <= rvr_nxt;
    rvm_r     <= rvm_nxt;
    t_r       <= t_nxt;
    mode_r    <= mode_nxt;
    vr_tz_r   <= vr_tz_nxt;
    vm_tz_r   <= vm_tz_nxt;
    last_r    <= last_nxt;
    removed_r <= removed_nxt;
    trail_r   <= trail_nxt;
    sig_r     <= sig_nxt;
    exp_r     <= exp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    bits_nxt      = bits_r;
    zero_nxt      = zero_r;
    mv_nxt        = mv_r;
    e2_nxt        = e2_r;
    accept_nxt    = accept_r;
    mm_nxt        = mm_r;
    ge_nxt        = ge_r;
    q_nxt         = q_r;
    e10_nxt       = e10_r;
    idx_nxt       = idx_r;
    amt_nxt       = amt_r;
    k_nxt         = k_r;
    wcnt_nxt      = wcnt_r;
    iss_nxt       = iss_r;
    cap_nxt       = cap_r;
    cnt_nxt       = cnt_r;
    tmp_nxt       = tmp_r;
    vr_nxt        = vr_r;
    vp_nxt        = vp_r;
    vm_nxt        = vm_r;
    qvr_nxt       = qvr_r;
    qvp_nxt       = qvp_r;
    qvm_nxt       = qvm_r;
    rvr_nxt       = rvr_r;
    rvm_nxt       = rvm_r;
    t_nxt         = t_r;
    mode_nxt      = mode_r;
    vr_tz_nxt     = vr_tz_r;
    vm_tz_nxt     = vm_tz_r;
    last_nxt      = last_r;
    removed_nxt   = removed_r;
    trail_nxt     = trail_r;
    sig_nxt       = sig_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;
    dv_in_valid   = 1'b0;
    dv_in         = '0;

    ex    = bits_r[IN_W-1:MANT_BITS];
    xabs  = ge_r ? 11'(e2_r) : 11'(-e2_r);
    lprod = 59'(xabs) * 59'(ge_r ? LOG10_2_MUL : LOG10_5_MUL);
    lg    = ge_r ? 10'(lprod >> 49) : 10'(lprod >> 48);
    qv    = lg - ((ge_r ? (xabs > 11'd3) : (xabs > 11'd1)) ? 10'd1 : 10'd0);
    ii    = xabs - 11'(qv);
    b5    = pow5_bits(idx_r);
    if (ge_r) begin
      sh = 12'(q_r) - e2_r + 12'(b5) + 12'(MUL_BITS - 1);
    end else begin
      sh = 12'(q_r) - 12'(b5) + 12'(MUL_BITS);
    end
    shin  = (wcnt_r == 2'd0) ? acc : tmp_r;
    shv   = shin >> amt_r;
    lastf = (vr_tz_r && last_r == 4'd5 && !vr_r[0]) ? 4'd4 : last_r;
    inc   = ((vr_r == vm_r) && (!accept_r || !vm_tz_r)) || (lastf >= 4'd5);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          bits_nxt  = in_ch.double_bits;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        zero_nxt   = (bits_r == '0);
        if (ex == '0) begin
          mv_nxt = {1'b0, bits_r[MANT_BITS-1:0], 2'b00};
          e2_nxt = 12'sd1 - 12'(E2_OFFSET);
        end else begin
          mv_nxt = {1'b1, bits_r[MANT_BITS-1:0], 2'b00};
          e2_nxt = 12'(ex) - 12'(E2_OFFSET);
        end
        accept_nxt = !bits_r[0];
        mm_nxt     = (bits_r[MANT_BITS-1:0] != '0) || (ex <= 11'd1);
        ge_nxt     = (ex >= 11'(E2_OFFSET));
        state_nxt  = (bits_r == '0) ? S_FIN : S_LOG;
      end
      S_LOG: begin
        if (ge_r) begin
          q_nxt   = (qv > 10'(INV_ROWS - 1)) ? 10'(INV_ROWS - 1) : qv;
          e10_nxt = q_nxt;
          idx_nxt = ROW_AW'(q_nxt);
        end else begin
          q_nxt   = qv;
          e10_nxt = 10'(12'(qv) + e2_r);
          idx_nxt = (ii > 11'(POW_ROWS - 1)) ? ROW_AW'(POW_ROWS - 1) : ROW_AW'(ii);
        end
        state_nxt = S_SH;
      end
      S_SH: begin
        if (sh < 12'sd64) begin
          amt_nxt = 8'd64;
        end else if (sh > 12'sd255) begin
          amt_nxt = 8'd255;
        end else begin
          amt_nxt = 8'(sh);
        end
        mac_ctl.clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        // Partial products of the 55-bit significand against four multiplier limbs.
        mac_a         = k_r[2] ? 32'(mv_r[54:32]) : mv_r[31:0];
        mac_b         = m_ext[{k_r[1:0], 5'b0} +: 32];
        mac_ctl.valid = 1'b1;
        mac_ctl.pos   = {1'b0, k_r[1:0]} + {2'b0, k_r[2]};
        k_nxt         = k_r + 3'd1;
        wcnt_nxt      = '0;
        if (k_r == 3'd7) begin
          state_nxt = S_MULW;
        end
      end
      S_MULW: begin
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'd1) begin
          wcnt_nxt  = '0;
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        // The upper and lower bounds are the center product plus 2M and minus M or 2M.
        wcnt_nxt = wcnt_r + 2'd1;
        case (wcnt_r)
          2'd0: begin
            vr_nxt  = 64'(shv);
            tmp_nxt = acc + (ACC_W'(rom_q) << 1);
          end
          2'd1: begin
            vp_nxt  = 64'(shv);
            tmp_nxt = acc - (mm_r ? (ACC_W'(rom_q) << 1) : ACC_W'(rom_q));
          end
          default: begin
            vm_nxt    = 64'(shv);
            state_nxt = S_TZ;
          end
        endcase
      end
      S_TZ: begin
        vr_tz_nxt   = 1'b0;
        vm_tz_nxt   = 1'b0;
        last_nxt    = '0;
        removed_nxt = '0;
        trail_nxt   = 1'b0;
        iss_nxt     = '0;
        state_nxt   = S_RISS;
        if (ge_r) begin
          if (q_r <= 10'd21) begin
            state_nxt = S_P5F;
          end
        end else if (q_r <= 10'd1) begin
          vr_tz_nxt = 1'b1;
          if (accept_r) begin
            vm_tz_nxt = mm_r;
          end else begin
            vp_nxt = vp_r - 64'd1;
          end
        end else if (q_r < 10'd63) begin
          vr_tz_nxt = ((64'(mv_r) & ((64'd1 << q_r[5:0]) - 64'd1)) == '0);
        end
      end
      S_P5F: begin
        // Dividing 2v by ten gives v/5 with twice v mod 5 as the remainder.
        dv_in_valid = 1'b1;
        dv_in       = {8'b0, mv_r, 1'b0};
        state_nxt   = S_P5FW;
      end
      S_P5FW: begin
        if (dv_out_valid) begin
          cnt_nxt = '0;
          if (dv_rem == 4'd0) begin
            mode_nxt = P5_VR;
            t_nxt    = mv_r;
          end else if (accept_r) begin
            mode_nxt = P5_VM;
            t_nxt    = mv_r - 55'd1 - 55'(mm_r);
          end else begin
            mode_nxt = P5_VP;
            t_nxt    = mv_r + 55'd2;
          end
          state_nxt = S_P5L;
        end
      end
      S_P5L: begin
        if (10'(cnt_r) >= q_r) begin
          case (mode_r)
            P5_VR:   vr_tz_nxt = 1'b1;
            P5_VM:   vm_tz_nxt = 1'b1;
            default: vp_nxt    = vp_r - 64'd1;
          endcase
          iss_nxt   = '0;
          state_nxt = S_RISS;
        end else begin
          dv_in_valid = 1'b1;
          dv_in       = {8'b0, t_r, 1'b0};
          state_nxt   = S_P5W;
        end
      end
      S_P5W: begin
        if (dv_out_valid) begin
          if (dv_rem != 4'd0) begin
            iss_nxt   = '0;
            state_nxt = S_RISS;
          end else begin
            t_nxt     = dv_quo[54:0];
            cnt_nxt   = cnt_r + 5'd1;
            state_nxt = S_P5L;
          end
        end
      end
      S_RISS: begin
        dv_in_valid = 1'b1;
        case (iss_r)
          2'd0:    dv_in = vr_r;
          2'd1:    dv_in = vp_r;
          default: dv_in = vm_r;
        endcase
        iss_nxt = iss_r + 2'd1;
        cap_nxt = '0;
        if (iss_r == 2'd2) begin
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (dv_out_valid) begin
          cap_nxt = cap_r + 2'd1;
          case (cap_r)
            2'd0: begin
              qvr_nxt = dv_quo;
              rvr_nxt = dv_rem;
            end
            2'd1: begin
              qvp_nxt = dv_quo;
            end
            default: begin
              qvm_nxt   = dv_quo;
              rvm_nxt   = dv_rem;
              state_nxt = S_RDEC;
            end
          endcase
        end
      end
      S_RDEC: begin
        iss_nxt = '0;
        if (!trail_r) begin
          // Main loop: drop a digit while the bounds still differ above it.
          if (qvp_r > qvm_r) begin
            vm_tz_nxt   = vm_tz_r && (rvm_r == 4'd0);
            vr_tz_nxt   = vr_tz_r && (last_r == 4'd0);
            last_nxt    = rvr_r;
            vr_nxt      = qvr_r;
            vp_nxt      = qvp_r;
            vm_nxt      = qvm_r;
            removed_nxt = removed_r + 5'd1;
            state_nxt   = S_RISS;
          end else if (vm_tz_r) begin
            trail_nxt = 1'b1;
            state_nxt = S_RISS;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          // Exact lower bound: keep stripping its trailing zeros.
          if (rvm_r != 4'd0) begin
            state_nxt = S_FIN;
          end else begin
            vr_tz_nxt   = vr_tz_r && (last_r == 4'd0);
            last_nxt    = rvr_r;
            vr_nxt      = qvr_r;
            vp_nxt      = qvp_r;
            vm_nxt      = qvm_r;
            removed_nxt = removed_r + 5'd1;
            state_nxt   = (qvm_r == '0) ? S_FIN : S_RISS;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            sig_nxt = '0;
            exp_nxt = '0;
          end else begin
            sig_nxt = SIG_W'(vr_r + 64'(inc));
            exp_nxt = e10_r + 10'(removed_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/sdd_rom.sv]
`timescale 1ns / 1ps
// Power-of-five multiplier tables with a registered read port.
// Depends on sdd_pkg for the table builders.
module sdd_rom import sdd_pkg::*; (
  input  logic              clk,
  input  logic              sel_inv,
  input  logic [ROW_AW-1:0] addr,
  output logic [MUL_W-1:0]  data_r
);

  localparam inv_tbl_t INV_TBL = build_inv_tbl();
  localparam pow_tbl_t POW_TBL = build_pow_tbl();

  always_ff @(posedge clk) begin
    if (sel_inv) begin
      data_r <= INV_TBL[addr];
    end else begin
      data_r <= POW_TBL[addr];
    end
  end

endmodule

[sv/sdd_mac.sv]
`timescale 1ns / 1ps
// Shared 32x32 multiplier with a shifted 192-bit accumulator behind it.
// Depends on sdd_pkg for the control struct.
module sdd_mac import sdd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mac_ctl_t         ctl,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic [ACC_W-1:0] acc_r
);

  logic [63:0] prod_r;
  logic [2:0]  pos_r;
  logic        v_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    pos_r  <= ctl.pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      v_r   <= 1'b0;
      acc_r <= '0;
    end else begin
      v_r <= ctl.valid;
      if (v_r) begin
        acc_r <= acc_r + (ACC_W'(prod_r) << {pos_r, 5'b0});
      end
    end
  end

endmodule

[sv/sdd_div10.sv]
`timescale 1ns / 1ps
// Four-stage pipelined divide-by-ten of a 64-bit value, quotient and remainder.
// Depends on sdd_pkg only through the common import.
module sdd_div10 import sdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] in_data,
  output logic        out_valid,
  output logic [63:0] out_quo,
  output logic [3:0]  out_rem
);

  logic [63:0] x1_r, x2_r, x3_r;
  logic [63:0] u1_r, w2_r, y3_r, ten3_r;
  logic [3:0]  v_r;
  logic [63:0] t1, u1, v2, w2, z3, y3, r4;

  always_comb begin
    t1 = (in_data >> 1) + (in_data >> 2);
    u1 = t1 + (t1 >> 4);
    v2 = u1_r + (u1_r >> 8);
    w2 = v2 + (v2 >> 16);
    z3 = w2_r + (w2_r >> 32);
    y3 = z3 >> 3;
    r4 = x3_r - ten3_r;
  end

  always_ff @(posedge clk) begin
    x1_r   <= in_data;
    u1_r   <= u1;
    x2_r   <= x1_r;
    w2_r   <= w2;
    x3_r   <= x2_r;
    y3_r   <= y3;
    ten3_r <= (y3 << 3) + (y3 << 1);
    if (r4 > 64'd9) begin
      out_quo <= y3_r + 64'd1;
      out_rem <= 4'(r4 - 64'd10);
    end else begin
      out_quo <= y3_r;
      out_rem <= 4'(r4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  assign out_valid = v_r[3];

endmodule

[sv/sdd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the shortest double-to-decimal block, bound to the top level.
// Depends on sdd_pkg for field widths.
module sdd_checker import sdd_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SIG_W-1:0]        out_sig,
  input logic signed [EXP_W-1:0] out_exp
);

  // The block works on one beat at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a beat is in flight");

  // Nothing comes out right after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A zero significand only ever comes with a zero exponent.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sig == '0) |-> (out_exp == '0))
    else $error("zero significand with nonzero exponent");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_sig) && $stable(out_exp)))
    else $error("result changed while stalled");

endmodule

bind shortest_double_to_decimal sdd_checker u_sdd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_sig  (out_ch.decimal_significand),
  .out_exp  (out_ch.decimal_exponent)
);
